>>> sv/tcgm_pkg.sv
// Shared types, constants and tables of the track-cluster gated match unit.
package tcgm_pkg;

  localparam int MAX_CLUSTERS = 256;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = IDX_W + 1;

  // Configuration register indexes
  localparam logic [2:0] CFG_CALO_RADIUS    = 3'd0;
  localparam logic [2:0] CFG_PHI_WINDOW     = 3'd1;
  localparam logic [2:0] CFG_Z_WINDOW       = 3'd2;
  localparam logic [2:0] CFG_ENERGY_FLOOR   = 3'd3;
  localparam logic [2:0] CFG_MOMENTUM_FLOOR = 3'd4;

  // Request command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_MATCH = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MATCH = 2'd2
  } op_e;

  // Classified request as held in the queue
  typedef struct packed {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        energy;
    logic [15:0]        momentum;
  } item_t;

  // atan(2^-i) in binary angle units pi/32768
  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/tcgm_if.sv
// Request and result channel interfaces.
interface tcgm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        energy;
  logic [15:0]        momentum;
  modport source(output valid, cmd, pos_x, pos_y, pos_z, energy, momentum, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pos_z, energy, momentum, output ready);
endinterface

interface tcgm_out_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [7:0]         cluster_index;
  logic signed [15:0] phi_diff;
  logic signed [15:0] z_diff;
  logic [17:0]        score_sq;
  modport source(output valid, matched, cluster_index, phi_diff, z_diff, score_sq,
                 input ready);
  modport sink(input valid, matched, cluster_index, phi_diff, z_diff, score_sq,
               output ready);
endinterface

>>> sv/track_cluster_gated_match_unit.sv
// Top level of the track-cluster gated match unit: configuration registers, front and back ends.
//
// Requests are clear, load cluster and match track; only match returns a result.
// A load runs the multiply states LD_MUL and LD_SQ, 16 CORDIC steps for the azimuth and
// 16 steps of the bit-serial search for the scaled z. A match that passes the momentum
// floor runs 16 CORDIC steps for the track azimuth, a scan that reads one cluster per cycle
// from the single-port store through a four-stage scoring pipeline, then 17 steps of the
// score divider. A two-entry queue and the result register let requests and results flow
// while the back end is busy. Configuration may change only while the unit is idle.
module track_cluster_gated_match_unit import tcgm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcgm_in_if.sink     in_ch,
  tcgm_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [14:0]      calo_radius_q, phi_window_q, z_window_q;
  logic [15:0]      energy_floor_q, momentum_floor_q;
  logic             item_valid, pop;
  item_t            item;
  logic [CNT_W-1:0] count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calo_radius_q    <= 15'd5984;
      phi_window_q     <= 15'd1043;
      z_window_q       <= 15'd640;
      energy_floor_q   <= 16'd0;
      momentum_floor_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CALO_RADIUS:    calo_radius_q    <= cfg_data_i[14:0];
        CFG_PHI_WINDOW:     phi_window_q     <= cfg_data_i[14:0];
        CFG_Z_WINDOW:       z_window_q       <= cfg_data_i[14:0];
        CFG_ENERGY_FLOOR:   energy_floor_q   <= cfg_data_i;
        CFG_MOMENTUM_FLOOR: momentum_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcgm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tcgm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .pop_o            (pop),
    .calo_radius_i    (calo_radius_q),
    .phi_window_i     (phi_window_q),
    .z_window_i       (z_window_q),
    .energy_floor_i   (energy_floor_q),
    .momentum_floor_i (momentum_floor_q),
    .count_o          (count),
    .out_ch           (out_ch)
  );

  // Store never overfills
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond store depth");

  // An unmatched result carries zero fields
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.matched) |->
      (out_ch.cluster_index == 8'd0 && out_ch.phi_diff == 16'sd0 &&
       out_ch.z_diff == 16'sd0 && out_ch.score_sq == 18'd0))
    else $error("unmatched result with nonzero fields");

  // Score of a gated candidate is at most two
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.matched) |-> (out_ch.score_sq <= 18'd131072))
    else $error("score out of range");

  // The back end takes a queued request only when one is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item_valid)
    else $error("pop from empty queue");

endmodule

>>> sv/tcgm_front.sv
// Front end: accepts requests, decodes the command and queues them for the back end.
module tcgm_front import tcgm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tcgm_in_if.sink in_ch,
  input  logic   pop_i,
  output logic   item_valid_o,
  output item_t  item_o
);

  item_t      fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, pop;
  item_t      cls;

  assign in_ch.ready  = (cnt_q != 2'd2);
  assign accept       = in_ch.valid && in_ch.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign pop          = pop_i && item_valid_o;

  // Decode; the unused command code is accepted and dropped
  always_comb begin
    cls.x        = in_ch.pos_x;
    cls.y        = in_ch.pos_y;
    cls.z        = in_ch.pos_z;
    cls.energy   = in_ch.energy;
    cls.momentum = in_ch.momentum;
    push         = accept;
    case (in_ch.cmd)
      CMD_CLEAR: cls.op = OP_CLEAR;
      CMD_LOAD:  cls.op = OP_LOAD;
      CMD_MATCH: cls.op = OP_MATCH;
      default: begin
        cls.op = OP_CLEAR;
        push   = 1'b0;
      end
    endcase
  end

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> sv/tcgm_back.sv
// Back end: cluster store, shared CORDIC, z scaling, candidate scan and score divider.
module tcgm_back import tcgm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             pop_o,
  input  logic [14:0]      calo_radius_i,
  input  logic [14:0]      phi_window_i,
  input  logic [14:0]      z_window_i,
  input  logic [15:0]      energy_floor_i,
  input  logic [15:0]      momentum_floor_i,
  output logic [CNT_W-1:0] count_o,
  tcgm_out_if.source       out_ch
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_LD_MUL   = 11'b00000000010,
    ST_LD_SQ    = 11'b00000000100,
    ST_CORDIC   = 11'b00000001000,
    ST_SQRT     = 11'b00000010000,
    ST_STORE    = 11'b00000100000,
    ST_M_PREP   = 11'b00001000000,
    ST_SCAN     = 11'b00010000000,
    ST_DIV_INT  = 11'b00100000000,
    ST_DIV_FRAC = 11'b01000000000,
    ST_EMIT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Request registers
  logic signed [15:0] x_q, y_q, z_q;
  logic [15:0]        energy_q, mom_q;
  logic               is_match_q, origin_q;
  logic [CNT_W-1:0]   cnt_q;

  // Load arithmetic
  logic [31:0] xx_q, yy_q, s_q;
  logic [29:0] num_q;
  logic [59:0] target_q;

  // CORDIC
  logic signed [31:0] cx_q, cy_q;
  logic [15:0]        acc_q;
  logic [3:0]         it_q;

  // z scaling search
  logic [59:0] p_q;
  logic [47:0] qacc_q;
  logic [15:0] n_q;

  // Cluster store {usable, scaled z, azimuth}
  logic [32:0] mem [MAX_CLUSTERS];
  logic [32:0] rd_q;

  // Match
  logic [29:0]      pw2_q, zw2_q;
  logic [59:0]      d_q;
  logic [15:0]      tphi_q;
  logic [CNT_W-1:0] k_q;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic [15:0]      dp2_q, dp3_q, dp4_q, dz2_q, dz3_q, dz4_q;
  logic [14:0]      ap2_q, az2_q;
  logic [29:0]      aps_q, azs_q;
  logic [59:0]      t1_q, t2_q;
  logic             found_q;
  logic [60:0]      best_key_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [15:0]      best_dp_q, best_dz_q;
  logic [60:0]      r_q;
  logic [17:0]      qd_q;

  // Result register
  logic        out_v_q;
  logic        out_m_q;
  logic [7:0]  out_idx_q;
  logic [15:0] out_dp_q, out_dz_q;
  logic [17:0] out_sc_q;

  // ---------------- combinational helpers ----------------
  logic [14:0] pw_eff, zw_eff;
  assign pw_eff = (phi_window_i == 15'd0) ? 15'd1 : phi_window_i;
  assign zw_eff = (z_window_i == 15'd0) ? 15'd1 : z_window_i;

  // |z| and load products
  logic [15:0]        absz;
  logic signed [31:0] xx_w, yy_w;
  logic [30:0]        num_w;
  assign absz  = z_q[15] ? 16'(-z_q) : 16'(z_q);
  assign xx_w  = x_q * x_q;
  assign yy_w  = y_q * y_q;
  assign num_w = 31'(calo_radius_i) * 31'(absz);

  // CORDIC start: scale by 4096 and rotate into the right half plane
  logic signed [31:0] ix, iy, c0x, c0y;
  logic [15:0]        c0acc;
  always_comb begin
    ix = {{4{x_q[15]}}, x_q, 12'b0};
    iy = {{4{y_q[15]}}, y_q, 12'b0};
    c0x   = ix;
    c0y   = iy;
    c0acc = 16'd0;
    if (x_q[15]) begin
      if (!y_q[15]) begin
        c0x   = iy;
        c0y   = -ix;
        c0acc = 16'h4000;
      end else begin
        c0x   = -iy;
        c0y   = ix;
        c0acc = 16'hC000;
      end
    end
  end

  // One CORDIC vectoring step
  logic signed [31:0] xs, ys, cnx, cny;
  logic [15:0]        cnacc;
  always_comb begin
    xs = cx_q >>> it_q;
    ys = cy_q >>> it_q;
    if (!cy_q[31]) begin
      cnx   = cx_q + ys;
      cny   = cy_q - xs;
      cnacc = acc_q + atan_lut(it_q);
    end else begin
      cnx   = cx_q - ys;
      cny   = cy_q + xs;
      cnacc = acc_q - atan_lut(it_q);
    end
  end

  // One bit of the z scaling search: (n + 2^k)^2 * s against target
  logic [65:0] trial;
  logic        trial_ok;
  assign trial = 66'(p_q) + (66'(qacc_q) << (it_q + 5'd1)) + (66'(s_q) << {it_q, 1'b0});
  assign trial_ok = (trial <= 66'(target_q));

  // Scaled z from the search result
  logic [15:0] nclamp, sz_w;
  always_comb begin
    nclamp = (n_q > 16'd32768) ? 16'd32768 : n_q;
    if (z_q[15]) begin
      sz_w = 16'(-nclamp);
    end else begin
      sz_w = (nclamp > 16'd32767) ? 16'd32767 : nclamp;
    end
  end

  // Scan stage A: differences and window gate
  logic [15:0]        rd_az, rd_sz, dp_w;
  logic signed [16:0] dz_w;
  logic [16:0]        ap_w, az_w;
  logic               pass_w;
  always_comb begin
    rd_az  = rd_q[15:0];
    rd_sz  = rd_q[31:16];
    dp_w   = tphi_q - rd_az;
    dz_w   = {z_q[15], z_q} - {rd_sz[15], rd_sz};
    ap_w   = dp_w[15] ? 17'(-{dp_w[15], dp_w}) : {1'b0, dp_w};
    az_w   = dz_w[16] ? 17'(-dz_w) : 17'(dz_w);
    pass_w = rd_q[32] && (ap_w <= {2'b0, pw_eff}) && (az_w <= {2'b0, zw_eff});
  end

  logic [60:0] key_w;
  assign key_w = {1'b0, t1_q} + {1'b0, t2_q};

  logic [60:0] r2_w;
  assign r2_w = {r_q[59:0], 1'b0};

  logic scan_done, out_free;
  assign scan_done = (k_q == cnt_q) && !v1_q && !v2_q && !v3_q && !v4_q;
  assign out_free  = !out_v_q || out_ch.ready;

  assign pop_o   = (state_q == ST_IDLE) && item_valid_i;
  assign count_o = cnt_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            OP_LOAD:  state_d = (cnt_q == CNT_W'(MAX_CLUSTERS)) ? ST_IDLE : ST_LD_MUL;
            OP_MATCH: state_d = ST_M_PREP;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_MUL: state_d = ST_LD_SQ;
      ST_LD_SQ:  state_d = ST_CORDIC;
      ST_CORDIC: begin
        if (it_q == 4'd15) begin
          if (is_match_q)    state_d = ST_SCAN;
          else if (origin_q) state_d = ST_STORE;
          else               state_d = ST_SQRT;
        end
      end
      ST_SQRT:   state_d = (it_q == 4'd0) ? ST_STORE : ST_SQRT;
      ST_STORE:  state_d = ST_IDLE;
      ST_M_PREP: state_d = (mom_q < momentum_floor_i) ? ST_EMIT : ST_CORDIC;
      ST_SCAN: begin
        if (scan_done) state_d = found_q ? ST_DIV_INT : ST_EMIT;
      end
      ST_DIV_INT:  state_d = ST_DIV_FRAC;
      ST_DIV_FRAC: state_d = (it_q == 4'd0) ? ST_EMIT : ST_DIV_FRAC;
      ST_EMIT:     state_d = out_free ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && item_i.op == OP_CLEAR) begin
        cnt_q <= '0;
      end else if (state_q == ST_STORE) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // scan pipeline valids
      v1_q <= (state_q == ST_SCAN) && (k_q != cnt_q);
      v2_q <= v1_q && pass_w;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (state_q == ST_M_PREP) begin
        found_q <= 1'b0;
      end else if (v4_q && (!found_q || key_w < best_key_q)) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    d_q <= {30'b0, pw2_q} * {30'b0, zw2_q};
    case (state_q)
      ST_IDLE: begin
        x_q        <= item_i.x;
        y_q        <= item_i.y;
        z_q        <= item_i.z;
        energy_q   <= item_i.energy;
        mom_q      <= item_i.momentum;
        is_match_q <= (item_i.op == OP_MATCH);
      end
      ST_LD_MUL: begin
        xx_q  <= 32'(xx_w);
        yy_q  <= 32'(yy_w);
        num_q <= num_w[29:0];
      end
      ST_LD_SQ: begin
        s_q      <= xx_q + yy_q;
        target_q <= {30'b0, num_q} * {30'b0, num_q};
        origin_q <= (x_q == 16'sd0) && (y_q == 16'sd0);
        cx_q     <= c0x;
        cy_q     <= c0y;
        acc_q    <= c0acc;
        it_q     <= 4'd0;
      end
      ST_M_PREP: begin
        pw2_q    <= {15'b0, pw_eff} * {15'b0, pw_eff};
        zw2_q    <= {15'b0, zw_eff} * {15'b0, zw_eff};
        origin_q <= (x_q == 16'sd0) && (y_q == 16'sd0);
        cx_q     <= c0x;
        cy_q     <= c0y;
        acc_q    <= c0acc;
        it_q     <= 4'd0;
      end
      ST_CORDIC: begin
        cx_q  <= cnx;
        cy_q  <= cny;
        acc_q <= cnacc;
        // the search counts down from the top bit after the last step
        it_q  <= (it_q == 4'd15) ? 4'd15 : it_q + 4'd1;
        // set up the next phase on the last step
        if (it_q == 4'd15) begin
          tphi_q <= origin_q ? 16'd0 : cnacc;
          k_q    <= '0;
          p_q    <= '0;
          qacc_q <= '0;
          n_q    <= '0;
        end
      end
      ST_SQRT: begin
        if (trial_ok) begin
          p_q       <= trial[59:0];
          qacc_q    <= qacc_q + (48'(s_q) << it_q);
          n_q[it_q] <= 1'b1;
        end
        it_q <= it_q - 4'd1;
      end
      ST_SCAN: begin
        if (k_q != cnt_q) begin
          k_q <= k_q + CNT_W'(1);
        end
      end
      ST_DIV_INT: begin
        if (best_key_q >= {d_q, 1'b0}) begin
          r_q  <= best_key_q - {d_q, 1'b0};
          qd_q <= 18'd2;
        end else if (best_key_q >= {1'b0, d_q}) begin
          r_q  <= best_key_q - {1'b0, d_q};
          qd_q <= 18'd1;
        end else begin
          r_q  <= best_key_q;
          qd_q <= 18'd0;
        end
        it_q <= 4'd15;
      end
      ST_DIV_FRAC: begin
        if (r2_w >= {1'b0, d_q}) begin
          r_q  <= r2_w - {1'b0, d_q};
          qd_q <= {qd_q[16:0], 1'b1};
        end else begin
          r_q  <= r2_w;
          qd_q <= {qd_q[16:0], 1'b0};
        end
        it_q <= it_q - 4'd1;
      end
      default: ;
    endcase

    // cluster store
    if (state_q == ST_STORE) begin
      if (origin_q) begin
        mem[cnt_q[IDX_W-1:0]] <= '0;
      end else begin
        mem[cnt_q[IDX_W-1:0]] <= {energy_q >= energy_floor_i, sz_w, acc_q};
      end
    end
    rd_q   <= mem[k_q[IDX_W-1:0]];
    idx1_q <= k_q[IDX_W-1:0];

    // scan pipeline payload
    idx2_q <= idx1_q;
    dp2_q  <= dp_w;
    dz2_q  <= dz_w[15:0];
    ap2_q  <= ap_w[14:0];
    az2_q  <= az_w[14:0];
    idx3_q <= idx2_q;
    dp3_q  <= dp2_q;
    dz3_q  <= dz2_q;
    aps_q  <= {15'b0, ap2_q} * {15'b0, ap2_q};
    azs_q  <= {15'b0, az2_q} * {15'b0, az2_q};
    idx4_q <= idx3_q;
    dp4_q  <= dp3_q;
    dz4_q  <= dz3_q;
    t1_q   <= {30'b0, aps_q} * {30'b0, zw2_q};
    t2_q   <= {30'b0, azs_q} * {30'b0, pw2_q};

    // best candidate; strict compare keeps the earliest on a tie
    if (v4_q && (!found_q || key_w < best_key_q)) begin
      best_key_q <= key_w;
      best_idx_q <= idx4_q;
      best_dp_q  <= dp4_q;
      best_dz_q  <= dz4_q;
    end

    // result register
    if (state_q == ST_EMIT && out_free) begin
      out_m_q   <= found_q;
      out_idx_q <= found_q ? 8'(best_idx_q) : 8'd0;
      out_dp_q  <= found_q ? best_dp_q : 16'd0;
      out_dz_q  <= found_q ? best_dz_q : 16'd0;
      out_sc_q  <= found_q ? qd_q : 18'd0;
    end
  end

  assign out_ch.valid         = out_v_q;
  assign out_ch.matched       = out_m_q;
  assign out_ch.cluster_index = out_idx_q;
  assign out_ch.phi_diff      = out_dp_q;
  assign out_ch.z_diff        = out_dz_q;
  assign out_ch.score_sq      = out_sc_q;

endmodule

>>> sim/track_cluster_gated_match_unit_tb.sv
// Self-checking testbench of the track-cluster gated match unit.
`timescale 1ns / 1ps

module track_cluster_gated_match_unit_tb;
  import tcgm_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         LIMIT       = 3_000_000;
  localparam int         DRAIN       = 150;
  localparam int         SHOW_ERRORS = 10;

  typedef struct {
    bit                 matched;
    bit [7:0]           cluster_index;
    logic signed [15:0] phi_diff;
    logic signed [15:0] z_diff;
    bit [17:0]          score_sq;
  } match_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tcgm_in_if  in_ch ();
  tcgm_out_if out_ch ();

  track_cluster_gated_match_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the block's state and settings
  int unsigned     stored_count;
  bit [15:0]       stored_azimuth [MAX_CLUSTERS];
  bit signed [15:0] stored_scaled_z [MAX_CLUSTERS];
  bit              stored_usable [MAX_CLUSTERS];
  int unsigned     radius_r, phi_win_r, z_win_r, energy_floor_r, momentum_floor_r;

  match_res_t pending_matches[$];
  int  mismatches;
  int  requests_sent;
  int  matched_seen;
  int  unmatched_seen;
  int  cycles;
  bit  calm;
  int  stall_left;

  // Clock and watchdog
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // CORDIC azimuth in binary angle units
  function automatic bit [15:0] predict_azimuth(int x0, int y0);
    longint x, y, t, xs, ys;
    int acc;
    x = longint'(x0) * 4096;
    y = longint'(y0) * 4096;
    acc = 0;
    if (x0 == 0 && y0 == 0) return 16'd0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 16384;
      end else begin
        t = x; x = -y; y = t; acc = -16384;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += int'(atan_lut(i[3:0]));
      end else begin
        x = x - ys; y = y + xs; acc -= int'(atan_lut(i[3:0]));
      end
    end
    return acc[15:0];
  endfunction

  // Largest n with n^2 * s <= target, n capped at 32768
  function automatic longint unsigned root_search(longint unsigned s,
                                                  longint unsigned target);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid * s <= target) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit signed [15:0] predict_scaled_z(longint unsigned s, int z);
    longint unsigned mag, num, lo;
    int r;
    mag = (z < 0) ? -z : z;
    num = longint'(radius_r) * mag;
    lo = root_search(s, num * num);
    if (z < 0) begin
      r = -int'(lo);
      return r[15:0];
    end
    return (lo > 32767) ? 16'sd32767 : lo[15:0];
  endfunction

  function automatic void store_cluster(int x, int y, int z, int unsigned e);
    longint unsigned s;
    s = longint'(x) * x + longint'(y) * y;
    if (stored_count >= MAX_CLUSTERS) return;
    if (s == 0) begin
      stored_azimuth[stored_count]  = '0;
      stored_scaled_z[stored_count] = '0;
      stored_usable[stored_count]   = 1'b0;
    end else begin
      stored_azimuth[stored_count]  = predict_azimuth(x, y);
      stored_scaled_z[stored_count] = predict_scaled_z(s, z);
      stored_usable[stored_count]   = (e >= energy_floor_r);
    end
    stored_count++;
  endfunction

  // Best gated cluster for one track
  function automatic match_res_t predict_match(int x, int y, int z, int unsigned m);
    match_res_t res;
    longint unsigned pw, zw, pw2, zw2, ap, az, key, best_key, d, q, r;
    int tphi, dp, dz, diff;
    bit found;
    res = '{default: 0};
    if (m < momentum_floor_r) return res;
    pw = phi_win_r ? phi_win_r : 1;
    zw = z_win_r ? z_win_r : 1;
    pw2 = pw * pw;
    zw2 = zw * zw;
    found = 1'b0;
    best_key = 0;
    tphi = int'($signed(predict_azimuth(x, y)));
    for (int k = 0; k < stored_count; k++) begin
      if (!stored_usable[k]) continue;
      diff = tphi - int'(stored_azimuth[k]);
      dp = int'($signed(diff[15:0]));
      dz = z - int'(stored_scaled_z[k]);
      ap = (dp < 0) ? -dp : dp;
      az = (dz < 0) ? -dz : dz;
      if (ap > pw || az > zw) continue;
      key = ap * ap * zw2 + az * az * pw2;
      if (!found || key < best_key) begin
        found = 1'b1;
        best_key = key;
        res.cluster_index = k[7:0];
        res.phi_diff = dp[15:0];
        res.z_diff = dz[15:0];
      end
    end
    if (!found) return '{default: 0};
    d = pw2 * zw2;
    q = best_key / d;
    r = best_key % d;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    res.matched = 1'b1;
    res.score_sq = q[17:0];
    return res;
  endfunction

  // Result side: random stall bursts and field-by-field compare
  always @(posedge clk_i) begin
    match_res_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      if (out_ch.matched) matched_seen++;
      else unmatched_seen++;
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_r = pending_matches.pop_front();
        if (out_ch.matched !== exp_r.matched || out_ch.cluster_index !== exp_r.cluster_index
            || out_ch.phi_diff !== exp_r.phi_diff || out_ch.z_diff !== exp_r.z_diff
            || out_ch.score_sq !== exp_r.score_sq) begin
          mismatches++;
          if (mismatches <= SHOW_ERRORS)
            $display({"mismatch: exp m=%0d i=%0d dp=%0d dz=%0d s=%0d",
                      " got m=%0d i=%0d dp=%0d dz=%0d s=%0d"},
                     exp_r.matched, exp_r.cluster_index, exp_r.phi_diff, exp_r.z_diff,
                     exp_r.score_sq, out_ch.matched, out_ch.cluster_index,
                     out_ch.phi_diff, out_ch.z_diff, out_ch.score_sq);
        end
      end
    end
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one request and update the mirror when it is accepted
  task automatic send_request(logic [1:0] cmd, int x, int y, int z,
                              int unsigned e, int unsigned m);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.pos_x    <= x[15:0];
    in_ch.pos_y    <= y[15:0];
    in_ch.pos_z    <= z[15:0];
    in_ch.energy   <= e[15:0];
    in_ch.momentum <= m[15:0];
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    requests_sent++;
    case (cmd)
      CMD_CLEAR: stored_count = 0;
      CMD_LOAD:  store_cluster(x, y, z, e);
      CMD_MATCH: pending_matches.insert(pending_matches.size(), predict_match(x, y, z, m));
      default: ;
    endcase
  endtask

  // Wait until all results are back and the back end has run dry
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[15:0];
    case (idx)
      CFG_CALO_RADIUS:    radius_r = value & 32'h7FFF;
      CFG_PHI_WINDOW:     phi_win_r = value & 32'h7FFF;
      CFG_Z_WINDOW:       z_win_r = value & 32'h7FFF;
      CFG_ENERGY_FLOOR:   energy_floor_r = value & 32'hFFFF;
      CFG_MOMENTUM_FLOOR: momentum_floor_r = value & 32'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int unsigned rad, int unsigned pw, int unsigned zw,
                           int unsigned ef, int unsigned mf);
    settle();
    write_reg(CFG_CALO_RADIUS, rad);
    write_reg(CFG_PHI_WINDOW, pw);
    write_reg(CFG_Z_WINDOW, zw);
    write_reg(CFG_ENERGY_FLOOR, ef);
    write_reg(CFG_MOMENTUM_FLOOR, mf);
  endtask

  function automatic int rand_s16();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Corner positions, origin, quadrant edges, cut edges and the spare command
  task automatic test_directed();
    send_request(CMD_MATCH, 100, 100, 0, 0, 1000);
    send_request(CMD_LOAD, 5984, 0, 100, 500, 0);
    send_request(CMD_LOAD, 32767, 32767, 32767, 65535, 0);
    send_request(CMD_LOAD, -32768, -32768, -32768, 0, 65535);
    send_request(CMD_LOAD, 0, 0, 500, 65535, 0);
    send_request(CMD_LOAD, -1, 0, 0, 10, 0);
    send_request(CMD_LOAD, -5984, -1, -200, 10, 0);
    send_request(CMD_LOAD, 0, 32767, 32767, 10, 0);
    send_request(CMD_LOAD, 1, 0, -32768, 10, 0);
    send_request(CMD_LOAD, 5984, 0, 100, 500, 0);
    send_request(CMD_MATCH, 5984, 0, 100, 65535, 65535);
    send_request(CMD_MATCH, 0, 0, 0, 0, 0);
    send_request(CMD_MATCH, -32768, -32768, -32768, 100, 100);
    send_request(CMD_MATCH, 32767, 32767, 32767, 100, 100);
    send_request(CMD_MATCH, -5984, 0, -200, 100, 100);
    send_request(CMD_MATCH, 0, 5984, 32767, 100, 100);
    send_request(CMD_SPARE, 300, 300, 300, 300, 300);
    send_request(CMD_MATCH, 5984, 0, 100, 0, 0);
    send_request(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_request(CMD_MATCH, 5984, 0, 100, 0, 0);
    configure(5984, 1043, 640, 400, 200);
    send_request(CMD_LOAD, 5984, 0, 100, 399, 0);
    send_request(CMD_LOAD, 5984, 0, 100, 400, 0);
    send_request(CMD_MATCH, 5984, 0, 100, 199, 199);
    send_request(CMD_MATCH, 5984, 0, 100, 0, 200);
  endtask

  // Loads past the store size are dropped
  task automatic test_full_store();
    send_request(CMD_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < MAX_CLUSTERS + 3; i++)
      send_request(CMD_LOAD, 3000 + i, 2000, 150, 1000, 0);
    send_request(CMD_MATCH, 3000 + MAX_CLUSTERS + 2, 2000, 150, 0, 1000);
    send_request(CMD_MATCH, 3200, 2000, 150, 0, 1000);
  endtask

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // A cluster event: clusters around a track direction, then tracks against them
  task automatic run_event(int unsigned n_loads, int unsigned n_tracks);
    int tx, ty, tz, cx, cy, cz, spread, zspread;
    longint unsigned s;
    tx = $urandom_range(0, 24000) - 12000;
    ty = $urandom_range(0, 24000) - 12000;
    tz = $urandom_range(0, 16000) - 8000;
    spread = $urandom_range(1, 400);
    zspread = $urandom_range(1, 600);
    if ($urandom_range(0, 3) != 0) send_request(CMD_CLEAR, rand_s16(), rand_s16(),
                                                rand_s16(), $urandom_range(0, 65535),
                                                $urandom_range(0, 65535));
    for (int i = 0; i < n_loads; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request($urandom_range(0, 3) == 0 ? CMD_SPARE : CMD_LOAD, rand_s16(),
                     rand_s16(), rand_s16(), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
      end else begin
        cx = clamp16(tx + int'($urandom_range(0, 2 * spread)) - spread);
        cy = clamp16(ty + int'($urandom_range(0, 2 * spread)) - spread);
        s = longint'(cx) * cx + longint'(cy) * cy;
        cz = clamp16((longint'(tz + int'($urandom_range(0, 2 * zspread)) - zspread) *
                      longint'(root_search(1, s))) / longint'(radius_r ? radius_r : 1));
        send_request(CMD_LOAD, cx, cy, cz, $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
      end
    end
    for (int i = 0; i < n_tracks; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(CMD_MATCH, rand_s16(), rand_s16(), rand_s16(),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        send_request(CMD_MATCH, clamp16(tx + int'($urandom_range(0, 600)) - 300),
                     clamp16(ty + int'($urandom_range(0, 600)) - 300),
                     clamp16(tz + int'($urandom_range(0, 800)) - 400),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
  endtask

  task automatic test_random_phase(int unsigned n_items);
    int unsigned sent, nl, nt;
    sent = 0;
    while (sent < n_items) begin
      nl = $urandom_range(1, 12);
      nt = $urandom_range(1, 6);
      run_event(nl, nt);
      sent += nl + nt + 1;
    end
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.energy = '0;
    in_ch.momentum = '0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    cycles = 0;
    mismatches = 0;
    requests_sent = 0;
    matched_seen = 0;
    unmatched_seen = 0;
    stored_count = 0;
    radius_r = 5984;
    phi_win_r = 1043;
    z_win_r = 640;
    energy_floor_r = 0;
    momentum_floor_r = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    configure(5984, 1043, 640, 0, 0);
    test_full_store();
    test_random_phase(130);
    configure(32767, 32767, 32767, 0, 0);
    test_random_phase(110);
    configure(1, 1, 1, 65535, 65535);
    test_random_phase(40);
    configure(5984, 0, 0, 0, 0);
    test_random_phase(70);
    configure($urandom_range(1000, 32767), $urandom_range(50, 5000),
              $urandom_range(50, 5000), $urandom_range(0, 3000), $urandom_range(0, 3000));
    test_random_phase(170);
    configure($urandom_range(1, 32767), $urandom_range(1, 32767), $urandom_range(1, 32767),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
    test_random_phase(90);
    configure(5984, $urandom_range(300, 3000), $urandom_range(300, 3000), 0, 0);
    test_random_phase(110);
    calm = 1'b1;
    test_random_phase(120);
    settle();

    $display("sent %0d requests over eight register settings", requests_sent);
    $display("results: %0d matched, %0d unmatched, %0d mismatches",
             matched_seen, unmatched_seen, mismatches);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
